[design/cifst_pkg.sv]
// ----------------------------------------------------------------------------
// cifst_pkg: shared types and constants of the CAN frame statistics table
// Slot count, entry layout, command and status codes, item and result types.
// ----------------------------------------------------------------------------
package cifst_pkg;

	// Number of table slots (1 to 64) and the width of a slot index
	localparam int SLOT_COUNT = 64;
	localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	// Command codes
	localparam logic CMD_RECORD = 1'b0;
	localparam logic CMD_READ   = 1'b1;

	// Result status codes
	localparam logic [1:0] STATUS_NEW  = 2'd0;
	localparam logic [1:0] STATUS_UPD  = 2'd1;
	localparam logic [1:0] STATUS_FULL = 2'd2;
	localparam logic [1:0] STATUS_READ = 2'd3;

	// One table entry as held in the memory
	typedef struct packed {
		logic [1:0]  bus;
		logic [10:0] id;
		logic [31:0] count;
		logic [31:0] stamp;
		logic [3:0]  length;
		logic [63:0] payload;
	} entry_t;

	// One input item
	typedef struct packed {
		logic        command;
		logic [1:0]  bus_number;
		logic [10:0] can_id;
		logic [3:0]  length_code;
		logic [63:0] payload;
		logic [31:0] now_ms;
		logic [5:0]  read_index;
	} item_t;

	// One result item
	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  slot;
		logic [1:0]  slot_bus;
		logic [10:0] slot_id;
		logic [31:0] slot_count;
		logic [31:0] slot_time;
		logic [3:0]  slot_length;
		logic [63:0] slot_payload;
		logic [31:0] full_events;
	} result_t;

	// Low six bits of a slot index, zero extended for small tables
	function automatic logic [5:0] slot_field(input logic [SLOT_W-1:0] idx);
		logic [31:0] w;
		w = 32'(idx);
		return w[5:0];
	endfunction

endpackage

[design/cifst_mem.sv]
// ----------------------------------------------------------------------------
// cifst_mem: slot table storage
// One synchronous memory of entries with registered read data, plus one
// valid flag per slot cleared by reset; an unwritten slot reads as empty.
// ----------------------------------------------------------------------------
module cifst_mem (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [cifst_pkg::SLOT_W-1:0]  rd_addr,
	output cifst_pkg::entry_t             rd_entry,
	output logic                          rd_valid,
	input  logic                          wr_en,
	input  logic [cifst_pkg::SLOT_W-1:0]  wr_addr,
	input  cifst_pkg::entry_t             wr_entry
);

	cifst_pkg::entry_t                    mem_q [cifst_pkg::SLOT_COUNT];
	logic [cifst_pkg::SLOT_COUNT-1:0]     valid_q;
	cifst_pkg::entry_t                    rd_entry_q;
	logic                                 rd_valid_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_entry;
		end
	end

	// Read port, registered read data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_entry_q <= mem_q[rd_addr];
		end
	end

	// Valid flags, cleared at once by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_entry = rd_entry_q;
	assign rd_valid = rd_valid_q;

endmodule

[design/cifst_scan.sv]
// ----------------------------------------------------------------------------
// cifst_scan: command sequencer
// Walks the table one slot per cycle for a record command, reads one slot
// for a read command, writes the updated entry back and forms the result.
// ----------------------------------------------------------------------------
module cifst_scan (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  cifst_pkg::item_t              in_item,
	input  logic                          out_free,
	output logic                          res_valid,
	output cifst_pkg::result_t            res,
	output logic                          rd_en,
	output logic [cifst_pkg::SLOT_W-1:0]  rd_addr,
	input  cifst_pkg::entry_t             rd_entry,
	input  logic                          rd_valid,
	output logic                          wr_en,
	output logic [cifst_pkg::SLOT_W-1:0]  wr_addr,
	output cifst_pkg::entry_t             wr_entry
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EVAL = 1'b1;

	logic                          state_q;
	logic [cifst_pkg::SLOT_W-1:0]  idx_q;
	cifst_pkg::item_t              item_q;
	logic [31:0]                   ovf_q;

	logic                          accept;
	logic                          eval;
	logic                          is_read;
	logic [31:0]                   cur_count;
	logic                          empty;
	logic                          match;
	logic                          hit;
	logic                          last;
	logic                          advance;
	logic                          in_range;
	cifst_pkg::entry_t             new_entry;

	// Slot evaluation
	always_comb begin
		logic [31:0] ridx_w;
		logic [31:0] qidx_w;
		ridx_w    = 32'(in_item.read_index);
		qidx_w    = 32'(item_q.read_index);
		accept    = in_valid && in_ready;
		eval      = (state_q == S_EVAL);
		is_read   = (item_q.command == cifst_pkg::CMD_READ);
		cur_count = rd_valid ? rd_entry.count : 32'd0;
		empty     = (cur_count == 32'd0);
		match     = rd_valid && (rd_entry.bus == item_q.bus_number)
			&& (rd_entry.id == item_q.can_id);
		hit       = empty || match;
		last      = (idx_q == cifst_pkg::SLOT_W'(cifst_pkg::SLOT_COUNT - 1));
		in_range  = (qidx_w < 32'(cifst_pkg::SLOT_COUNT));
		advance   = eval && !is_read && !hit && !last;
		res_valid = eval && (is_read || hit || last) && out_free;

		rd_en = accept || advance;
		if (accept) begin
			rd_addr = (in_item.command == cifst_pkg::CMD_READ)
				? ridx_w[cifst_pkg::SLOT_W-1:0] : '0;
		end else begin
			rd_addr = idx_q + cifst_pkg::SLOT_W'(1);
		end

		new_entry.bus     = item_q.bus_number;
		new_entry.id      = item_q.can_id;
		new_entry.count   = cur_count + 32'd1;
		new_entry.stamp   = item_q.now_ms;
		new_entry.length  = item_q.length_code;
		new_entry.payload = item_q.payload;

		wr_en    = eval && !is_read && hit && out_free;
		wr_addr  = idx_q;
		wr_entry = new_entry;
	end

	// Result formation
	always_comb begin
		res             = '0;
		res.full_events = ovf_q;
		if (is_read) begin
			res.status = cifst_pkg::STATUS_READ;
			res.slot   = item_q.read_index;
			if (rd_valid && in_range) begin
				res.slot_bus     = rd_entry.bus;
				res.slot_id      = rd_entry.id;
				res.slot_count   = rd_entry.count;
				res.slot_time    = rd_entry.stamp;
				res.slot_length  = rd_entry.length;
				res.slot_payload = rd_entry.payload;
			end
		end else if (hit) begin
			res.status       = empty ? cifst_pkg::STATUS_NEW : cifst_pkg::STATUS_UPD;
			res.slot         = cifst_pkg::slot_field(idx_q);
			res.slot_bus     = new_entry.bus;
			res.slot_id      = new_entry.id;
			res.slot_count   = new_entry.count;
			res.slot_time    = new_entry.stamp;
			res.slot_length  = new_entry.length;
			res.slot_payload = new_entry.payload;
		end else begin
			res.status      = cifst_pkg::STATUS_FULL;
			res.full_events = ovf_q + 32'd1;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	// Item register, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_item;
		end
	end

	// Sequencer state, scan index and table-full counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			ovf_q   <= 32'd0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EVAL;
						idx_q   <= '0;
					end
				end
				S_EVAL: begin
					if (advance) begin
						idx_q <= idx_q + cifst_pkg::SLOT_W'(1);
					end
					if (res_valid) begin
						state_q <= S_IDLE;
						if (!is_read && !hit) begin
							ovf_q <= ovf_q + 32'd1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Checks
	a_accept_eval: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_EVAL))
		else $error("scan did not start after an accepted transfer");

	a_advance_step: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (idx_q == $past(idx_q) + cifst_pkg::SLOT_W'(1)))
		else $error("scan index did not step by one");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en))
		else $error("table read and write in the same cycle");

	a_result_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> out_free)
		else $error("result issued while output register occupied");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (res.status == cifst_pkg::STATUS_FULL))
		|=> (ovf_q == $past(ovf_q) + 32'd1))
		else $error("table-full counter not incremented");

endmodule

[design/can_id_frame_statistics_table_core.sv]
// Sequence: a read passes the registered memory read port and the output register;
//   a record scans from slot 0 until it settles in a slot or the table is full.
// Throughput: one command at a time; the next is taken once the result is
//   registered, and the scan steps through the table memory one slot per cycle.
// Reset: arst_n clears the slot valid flags and table-full counter at once, so
//   the table reads empty straight after reset with no clearing pass.
// ----------------------------------------------------------------------------
// can_id_frame_statistics_table_core: CAN frame statistics table
// Records frames per bus and identifier in a slot table and returns slots.
// ----------------------------------------------------------------------------
module can_id_frame_statistics_table_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	// bus_number[1:0], can_id[12:2], length_code[16:13], payload[80:17],
	// now_ms[112:81], read_index[118:113], zero[119]
	input  logic [119:0]  s_tdata,
	// command[0]
	input  logic [0:0]    s_tuser,
	output logic          m_tvalid,
	input  logic          m_tready,
	// slot[5:0], slot_bus[7:6], slot_id[18:8], slot_count[50:19],
	// slot_time[82:51], slot_length[86:83], slot_payload[150:87],
	// full_events[182:151], zero[183]
	output logic [183:0]  m_tdata,
	// status[1:0]
	output logic [1:0]    m_tuser
);

	cifst_pkg::item_t              in_item;
	cifst_pkg::result_t            res;
	logic                          res_valid;
	logic                          out_free;
	logic                          rd_en;
	logic [cifst_pkg::SLOT_W-1:0]  rd_addr;
	cifst_pkg::entry_t             rd_entry;
	logic                          rd_valid;
	logic                          wr_en;
	logic [cifst_pkg::SLOT_W-1:0]  wr_addr;
	cifst_pkg::entry_t             wr_entry;
	cifst_pkg::result_t            res_q;
	logic                          m_tvalid_q;

	// Input unpacking
	always_comb begin
		in_item.command     = s_tuser[0];
		in_item.bus_number  = s_tdata[1:0];
		in_item.can_id      = s_tdata[12:2];
		in_item.length_code = s_tdata[16:13];
		in_item.payload     = s_tdata[80:17];
		in_item.now_ms      = s_tdata[112:81];
		in_item.read_index  = s_tdata[118:113];
	end

	cifst_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_item   (in_item),
		.out_free  (out_free),
		.res_valid (res_valid),
		.res       (res),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_entry  (rd_entry),
		.rd_valid  (rd_valid),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_entry  (wr_entry)
	);

	cifst_mem u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_entry (rd_entry),
		.rd_valid (rd_valid),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_entry (wr_entry)
	);

	// Output register
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_free) begin
			m_tvalid_q <= res_valid;
		end
	end

	// Output packing
	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = res_q.status;
	assign m_tdata  = {1'b0, res_q.full_events, res_q.slot_payload, res_q.slot_length,
		res_q.slot_time, res_q.slot_count, res_q.slot_id, res_q.slot_bus, res_q.slot};

endmodule
